[hdl/s2lab_pkg.sv]
// ============================================================================
// s2lab_pkg
// Shared constants, the gamma table and the matrix for the sRGB to CIELAB
// conversion pipeline.
// ============================================================================
`default_nettype none

package s2lab_pkg;

   // Field widths
   localparam int CH_W   = 8;
   localparam int L_W    = 15;
   localparam int AB_W   = 16;

   // Internal fixed point (Q30)
   localparam int Q_SH   = 30;
   localparam int LIN_W  = 31;              // linear channel, up to 1.0
   localparam int COEF_W = 21;              // Q20 matrix coefficient
   localparam int PROD_W = LIN_W + COEF_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int T_W    = 32;              // tristimulus over white
   localparam int F_W    = 31;              // CIE f value
   localparam int SQ_W   = 2 * F_W;         // exact square of an f candidate
   localparam int E_W    = 42;              // signed L, a, b before rounding

   // Cube root search: one bit per pair of stages
   localparam int F_BITS = F_W;
   localparam int F_LAT  = 2 * F_BITS;
   localparam int LN_LAT = 4;               // linear segment of f

   localparam longint unsigned Q30 = 64'd1 << 30;
   localparam longint unsigned Q20 = 64'd1 << 20;
   localparam longint unsigned WX  = 64'd950489;
   localparam longint unsigned WZ  = 64'd108884;

   localparam longint unsigned CXR = (64'd412400 * Q20 + WX / 2) / WX;
   localparam longint unsigned CXG = (64'd357600 * Q20 + WX / 2) / WX;
   localparam longint unsigned CXB = (64'd180500 * Q20 + WX / 2) / WX;
   localparam longint unsigned CYR = (64'd2126 * Q20 + 64'd5000) / 64'd10000;
   localparam longint unsigned CYG = (64'd7152 * Q20 + 64'd5000) / 64'd10000;
   localparam longint unsigned CYB = (64'd722 * Q20 + 64'd5000) / 64'd10000;
   localparam longint unsigned CZR = (64'd1930 * Q20 + WZ / 2) / WZ;
   localparam longint unsigned CZG = (64'd11920 * Q20 + WZ / 2) / WZ;
   localparam longint unsigned CZB = (64'd95050 * Q20 + WZ / 2) / WZ;

   localparam logic [COEF_W-1:0] COEF [3][3] = '{
      '{COEF_W'(CXR), COEF_W'(CXG), COEF_W'(CXB)},
      '{COEF_W'(CYR), COEF_W'(CYG), COEF_W'(CYB)},
      '{COEF_W'(CZR), COEF_W'(CZG), COEF_W'(CZB)}
   };

   // f linear segment: f = (t*24389 + 432*2^30 + 1566) / 3132
   //   = 7t + LN_Q0 + (2465t + LN_R0) / 3132
   localparam longint unsigned LN_K    = 64'd432 * Q30 + 64'd1566;
   localparam longint unsigned LN_Q0   = LN_K / 64'd3132;
   localparam longint unsigned LN_R0   = LN_K % 64'd3132;
   localparam longint unsigned LN_DIV  = 64'd3132;
   localparam longint unsigned LN_M    = (64'd1 << 36) / 64'd3132;
   localparam longint unsigned T_KNEE  = (64'd216 * Q30) / 64'd24389;
   localparam int LN_T_W = 24;              // t below the knee
   localparam int LN_X_W = 36;
   localparam int LN_M_W = 25;
   localparam int LN_Q_W = 25;
   localparam int LN_B_W = 29;

   typedef logic [LIN_W-1:0] lin_tab_type [256];

   // Truncated Q30 fifth power
   function automatic longint unsigned pow5_q30(input longint unsigned z);
      longint unsigned z2;
      longint unsigned z4;
      z2 = (z * z) >> 30;
      z4 = (z2 * z2) >> 30;
      return (z4 * z) >> 30;
   endfunction

   // Gamma linearization of one 8-bit code, evaluated at elaboration
   function automatic longint unsigned lin_entry(input longint unsigned c);
      longint unsigned u;
      longint unsigned u2;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      if (c * 64'd100000 <= 64'd1031475) begin
         return ((64'd5 * c) << 30) / 64'd16473;
      end
      u  = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
      u2 = (u * u) >> 30;
      lo = 0;
      hi = Q30;
      for (int n = 0; n < 64; n++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (pow5_q30(mid) <= u2) lo = mid;
            else hi = mid - 1;
         end
      end
      return (u2 * lo) >> 30;
   endfunction

   function automatic lin_tab_type build_lin_tab();
      lin_tab_type tab;
      for (int c = 0; c < 256; c++) begin
         tab[c] = LIN_W'(lin_entry(longint'(c)));
      end
      return tab;
   endfunction

   localparam lin_tab_type LIN_TABLE = build_lin_tab();

endpackage

`default_nettype wire

[hdl/s2lab_if.sv]
// ============================================================================
// s2lab_req_if / s2lab_rsp_if
// Valid/ready channels for sRGB pixels in and CIELAB items out.
// ============================================================================
`default_nettype none

interface s2lab_req_if import s2lab_pkg::*;;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface s2lab_rsp_if import s2lab_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic        [L_W-1:0]  lightness;
   logic signed [AB_W-1:0] green_red_axis;
   logic signed [AB_W-1:0] blue_yellow_axis;

   modport source (output valid, lightness, green_red_axis, blue_yellow_axis,
                   input ready);
   modport sink   (input valid, lightness, green_red_axis, blue_yellow_axis,
                   output ready);
endinterface

`default_nettype wire

[hdl/s2lab_cief.sv]
// ============================================================================
// s2lab_cief
// CIE f function for one channel: bit-serial cube root search, one bit per
// two stages, with the linear segment computed alongside and delayed.
// ============================================================================
`default_nettype none

module s2lab_cief import s2lab_pkg::*; (
   input  wire logic           clock,
   input  wire logic           adv,
   input  wire logic [T_W-1:0] t_in,
   output logic      [F_W-1:0] f_out
);

   localparam int DLY = F_LAT - LN_LAT;

   // Cube root stages: A builds the candidate and its square, B tests it
   logic [F_W-1:0]  ca_f_ff  [F_BITS];
   logic [F_W-1:0]  ca_fo_ff [F_BITS];
   logic [SQ_W-1:0] ca_sq_ff [F_BITS];
   logic [SQ_W-1:0] ca_so_ff [F_BITS];
   logic [T_W-1:0]  ca_t_ff  [F_BITS];
   logic [F_W-1:0]  cb_f_ff  [F_BITS];
   logic [SQ_W-1:0] cb_s_ff  [F_BITS];
   logic [T_W-1:0]  cb_t_ff  [F_BITS];

   for (genvar i = 0; i < F_BITS; i++) begin : g_bit
      localparam int K = F_BITS - 1 - i;
      logic [F_W-1:0]       f_prev;
      logic [SQ_W-1:0]      s_prev;
      logic [T_W-1:0]       t_prev;
      logic [F_W-1:0]       cand_in;
      logic [SQ_W-1:0]      sq_in;
      logic [SQ_W:0]        prod;
      logic                 fits;

      if (i == 0) begin : g_first
         assign f_prev = '0;
         assign s_prev = '0;
         assign t_prev = t_in;
      end else begin : g_next
         assign f_prev = cb_f_ff[i-1];
         assign s_prev = cb_s_ff[i-1];
         assign t_prev = cb_t_ff[i-1];
      end

      // (F + 2^K)^2 = F^2 + F*2^(K+1) + 2^(2K); F has no bits at or below K
      assign cand_in = f_prev | (F_W'(1) << K);
      assign sq_in   = s_prev + (SQ_W'(f_prev) << (K + 1)) + (SQ_W'(1) << (2 * K));

      // truncated cube of the candidate against t
      assign prod = (SQ_W + 1)'(ca_sq_ff[i][SQ_W-1:Q_SH]) * (SQ_W + 1)'(ca_f_ff[i]);
      assign fits = prod[SQ_W:Q_SH] <= {1'b0, ca_t_ff[i]};

      always_ff @(posedge clock) begin
         if (adv) begin
            ca_f_ff[i]  <= cand_in;
            ca_fo_ff[i] <= f_prev;
            ca_sq_ff[i] <= sq_in;
            ca_so_ff[i] <= s_prev;
            ca_t_ff[i]  <= t_prev;
            cb_f_ff[i]  <= fits ? ca_f_ff[i]  : ca_fo_ff[i];
            cb_s_ff[i]  <= fits ? ca_sq_ff[i] : ca_so_ff[i];
            cb_t_ff[i]  <= ca_t_ff[i];
         end
      end
   end

   // Linear segment: reciprocal multiply with one correction step
   logic [LN_X_W-1:0]        ln1_x_ff;
   logic [LN_B_W-1:0]        ln1_b_ff;
   logic                     ln1_c_ff;
   logic [LN_X_W-1:0]        ln2_x_ff;
   logic [LN_B_W-1:0]        ln2_b_ff;
   logic [LN_Q_W-1:0]        ln2_q_ff;
   logic                     ln2_c_ff;
   logic [LN_X_W-1:0]        ln3_r_ff;
   logic [LN_B_W-1:0]        ln3_b_ff;
   logic [LN_Q_W-1:0]        ln3_q_ff;
   logic                     ln3_c_ff;
   logic [F_W-1:0]           dl_f_ff [DLY+1];
   logic                     dl_c_ff [DLY+1];
   logic [LN_T_W-1:0]        t_lo;
   logic [LN_X_W+LN_M_W-1:0] q_prod;

   assign t_lo   = t_in[LN_T_W-1:0];
   assign q_prod = (LN_X_W + LN_M_W)'(ln1_x_ff) * (LN_X_W + LN_M_W)'(LN_M_W'(LN_M));

   always_ff @(posedge clock) begin
      if (adv) begin
         ln1_x_ff <= LN_X_W'(LN_X_W'(t_lo) * LN_X_W'(2465)) + LN_X_W'(LN_R0);
         ln1_b_ff <= LN_B_W'(LN_B_W'(t_lo) * LN_B_W'(7)) + LN_B_W'(LN_Q0);
         ln1_c_ff <= {32'd0, t_in} > 64'(T_KNEE);
         ln2_x_ff <= ln1_x_ff;
         ln2_b_ff <= ln1_b_ff;
         ln2_q_ff <= q_prod[LN_X_W+LN_M_W-1:36];
         ln2_c_ff <= ln1_c_ff;
         ln3_r_ff <= ln2_x_ff - LN_X_W'(LN_X_W'(ln2_q_ff) * LN_X_W'(LN_DIV));
         ln3_b_ff <= ln2_b_ff;
         ln3_q_ff <= ln2_q_ff;
         ln3_c_ff <= ln2_c_ff;
         dl_f_ff[0] <= F_W'(ln3_b_ff) + F_W'(ln3_q_ff)
                     + F_W'(ln3_r_ff >= LN_X_W'(LN_DIV));
         dl_c_ff[0] <= ln3_c_ff;
         for (int j = 1; j <= DLY; j++) begin
            dl_f_ff[j] <= dl_f_ff[j-1];
            dl_c_ff[j] <= dl_c_ff[j-1];
         end
      end
   end

   // both paths line up after F_LAT stages
   assign f_out = dl_c_ff[DLY] ? cb_f_ff[F_BITS-1] : dl_f_ff[DLY];

endmodule

`default_nettype wire

[hdl/srgb_to_cielab.sv]
// ============================================================================
// srgb_to_cielab
// sRGB pixel to CIELAB (D65) converter, fully pipelined.
// ============================================================================
//
//   channel   dir   payload                                     handshake
//   req_ch    in    red, green, blue (8b each)                  valid/ready
//   rsp_ch    out   lightness (15b), green_red_axis,            valid/ready
//                   blue_yellow_axis (16b signed)
//
// One item per cycle unless stalled; stages: gamma table, matrix products, sum,
// 62 stages of bit-serial cube root (two per result bit), three output stages.
// All stages advance together whenever the output register is empty or taken.
// Synchronous reset clears only the valid bits; no state spans items.
// A stall holds every stage in place, so nothing is lost or repeated.
// ============================================================================
`default_nettype none

module srgb_to_cielab import s2lab_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   s2lab_req_if.sink    req_ch,
   s2lab_rsp_if.source  rsp_ch
);

   localparam int SH   = Q_SH - FRAC_BITS;
   localparam int PIPE = 3 + F_LAT + 3;
   localparam logic [E_W-1:0] HALF   = E_W'(1) << (SH - 1);
   localparam logic [E_W-1:0] LIM_L  = E_W'(100) << FRAC_BITS;
   localparam logic [E_W-1:0] LIM_AB = E_W'(128) << FRAC_BITS;

   logic adv;
   logic v_ff [PIPE];

   logic [LIN_W-1:0]  lin_ff  [3];
   logic [PROD_W-1:0] prod_ff [3][3];
   logic [T_W-1:0]    t_ff    [3];
   logic [F_W-1:0]    f_val   [3];
   logic signed [E_W-1:0] e_ff  [3];
   logic signed [E_W-1:0] e_in  [3];
   logic signed [E_W-1:0] f_s   [3];
   logic              neg_ff  [3];
   logic [E_W-1:0]    mag_ff  [3];
   logic [L_W-1:0]         lightness_ff;
   logic signed [AB_W-1:0] gra_ff;
   logic signed [AB_W-1:0] bya_ff;
   logic signed [AB_W-1:0] ab_in [2];

   // whole pipeline moves unless a finished item is waiting
   assign adv          = !v_ff[PIPE-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < PIPE; j++) v_ff[j] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_ch.valid;
         for (int j = 1; j < PIPE; j++) v_ff[j] <= v_ff[j-1];
      end
   end

   // Gamma table, matrix products, row sums
   always_ff @(posedge clock) begin
      if (adv) begin
         lin_ff[0] <= LIN_TABLE[req_ch.red];
         lin_ff[1] <= LIN_TABLE[req_ch.green];
         lin_ff[2] <= LIN_TABLE[req_ch.blue];
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= PROD_W'(lin_ff[c]) * PROD_W'(COEF[r][c]);
            end
            t_ff[r] <= T_W'((SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                           + SUM_W'(prod_ff[r][2]) + SUM_W'(Q20 >> 1)) >> 20);
         end
      end
   end

   // CIE f per channel
   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      s2lab_cief u_cief (
         .clock (clock),
         .adv   (adv),
         .t_in  (t_ff[ch]),
         .f_out (f_val[ch])
      );
      assign f_s[ch] = signed'(E_W'(f_val[ch]));
   end

   // L = 116 fY - 16, a = 500 (fX - fY), b = 200 (fY - fZ)
   assign e_in[0] = f_s[1] * E_W'(116) - (E_W'(16) << Q_SH);
   assign e_in[1] = (f_s[0] - f_s[1]) * E_W'(500);
   assign e_in[2] = (f_s[1] - f_s[2]) * E_W'(200);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            e_ff[k]   <= e_in[k];
            neg_ff[k] <= e_ff[k][E_W-1];
            // round half away from zero on the magnitude
            mag_ff[k] <= ((e_ff[k][E_W-1] ? E_W'(-e_ff[k]) : E_W'(e_ff[k])) + HALF) >> SH;
         end
      end
   end

   // Saturate and narrow
   for (genvar k = 1; k < 3; k++) begin : g_ab
      always_comb begin
         if (neg_ff[k]) begin
            ab_in[k-1] = AB_W'(mag_ff[k] > LIM_AB ? -LIM_AB : -mag_ff[k]);
         end else begin
            ab_in[k-1] = AB_W'(mag_ff[k] > LIM_AB - E_W'(1) ? LIM_AB - E_W'(1)
                                                            : mag_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (neg_ff[0]) lightness_ff <= '0;
         else lightness_ff <= L_W'(mag_ff[0] > LIM_L ? LIM_L : mag_ff[0]);
         gra_ff <= ab_in[0];
         bya_ff <= ab_in[1];
      end
   end

   assign rsp_ch.valid            = v_ff[PIPE-1];
   assign rsp_ch.lightness        = lightness_ff;
   assign rsp_ch.green_red_axis   = gra_ff;
   assign rsp_ch.blue_yellow_axis = bya_ff;

   // an accepted item enters the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> v_ff[0])
      else $error("accepted item missing from first stage");

   // a stall freezes the middle of the pipeline
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(v_ff[3]) && $stable(v_ff[PIPE-2])))
      else $error("pipeline moved during stall");

   // lightness never exceeds 100 when it fits the port
   a_lim: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && FRAC_BITS <= 8) |-> (E_W'(rsp_ch.lightness) <= LIM_L))
      else $error("lightness above full scale");

endmodule

`default_nettype wire
